[src/hbd_pkg.sv]
package hbd_pkg;

	// pixel format codes held in the configuration register
	localparam logic [1:0] FMT_YUY2  = 2'd0;
	localparam logic [1:0] FMT_RGB24 = 2'd1;
	localparam logic [1:0] FMT_RGB32 = 2'd2;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef logic [3:0][7:0] hbd_pix_t;

	typedef struct packed {
		logic [7:0] byte_d;
		logic [7:0] byte_c;
		logic [7:0] byte_b;
		logic [7:0] byte_a;
		logic       row_end;
	} hbd_in_t;

	typedef struct packed {
		logic [7:0] out_d;
		logic [7:0] out_c;
		logic [7:0] out_b;
		logic [7:0] out_a;
		logic       out_row_end;
	} hbd_out_t;

	typedef enum logic {
		OP_TAP3 = 1'b0,
		OP_TAP2 = 1'b1
	} hbd_kind_t;

	// one filter job handed from the front to the back
	typedef struct packed {
		hbd_kind_t  kind;
		logic [1:0] fmt;
		hbd_pix_t   left;
		hbd_pix_t   middle;
		hbd_pix_t   cur;
		logic       row_end;
	} hbd_op_t;

	function automatic logic [7:0] tap3(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] z);
		logic [9:0] s;
		s = {2'b00, x} + {1'b0, y, 1'b0} + {2'b00, z} + 10'd2;
		return s[9:2];
	endfunction

	function automatic logic [7:0] tap2(input logic [7:0] x, input logic [7:0] y);
		logic [8:0] s;
		s = {1'b0, x} + {1'b0, y} + 9'd1;
		return s[8:1];
	endfunction

endpackage

[src/horizontal_binomial_decimate_2to1.sv]
// Halves a pixel row horizontally with a rounded 1-2-1 filter. Each src
// transaction carries one RGB24 or RGB32 pixel, or one YUY2 pair, with
// row_end on the last item of a row; every second item from the third on
// yields one res transaction, and a row with an even item count closes with a
// rounded two-tap average (in YUY2 the first luma of that output keeps three
// taps). A one-item row gives nothing. The block takes one src transaction per
// clock while the queue is not full and issues at most one res transaction per
// clock; the item that completes a result writes its job into the queue, and
// the back registers the result in the output register when it takes the job.
// The front holds the row state and hands filter jobs into a two-entry queue;
// the back computes the taps and holds the result in an output register.
// src_ready drops only when the queue is full, i.e. when res_ready has been
// low long enough to back the queue up. pixel_format (0 YUY2, 1 RGB24,
// 2 RGB32, 3 behaves as RGB32), set via cfg_we/cfg_wdata, travels with each
// queued job; the user writes it only while the block is idle (not enforced).
module horizontal_binomial_decimate_2to1 #(
	parameter int unsigned QDEPTH = hbd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              src_valid,
	output logic              src_ready,
	input  hbd_pkg::hbd_in_t  src_data,
	output logic              res_valid,
	input  logic              res_ready,
	output hbd_pkg::hbd_out_t res_data
);

	// format register, yuy2 after reset
	logic [1:0]       fmt_q;

	// front to queue
	logic             push;
	hbd_pkg::hbd_op_t push_op;
	logic             full;

	// queue to back
	logic             pop;
	logic             empty;
	hbd_pkg::hbd_op_t head_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= hbd_pkg::FMT_YUY2;
		end else if (cfg_we) begin
			fmt_q <= cfg_wdata;
		end
	end

	// classify each item by row position, keep left and middle neighbours
	hbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fmt       (fmt_q),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.full      (full),
		.push      (push),
		.push_op   (push_op)
	);

	// decouples the front from output stalls
	hbd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head_op (head_op)
	);

	// filter arithmetic and registered output
	hbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head_op   (head_op),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

[src/hbd_front.sv]
module hbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        fmt,
	input  logic              src_valid,
	output logic              src_ready,
	input  hbd_pkg::hbd_in_t  src_data,
	input  logic              full,
	output logic              push,
	output hbd_pkg::hbd_op_t  push_op
);

	logic              take;
	hbd_pkg::hbd_pix_t cur;
	hbd_pkg::hbd_pix_t left_q;
	hbd_pkg::hbd_pix_t middle_q;
	logic              odd_q;
	logic              started_q;

	assign src_ready = !full;
	assign take      = src_valid && src_ready;
	assign cur       = {src_data.byte_d, src_data.byte_c, src_data.byte_b, src_data.byte_a};

	// a result is due on every even position past the first, and on a row end at odd
	assign push = take && started_q && (!odd_q || src_data.row_end);

	always_comb begin
		push_op.kind    = odd_q ? hbd_pkg::OP_TAP2 : hbd_pkg::OP_TAP3;
		push_op.fmt     = fmt;
		push_op.left    = left_q;
		push_op.middle  = middle_q;
		push_op.cur     = cur;
		push_op.row_end = src_data.row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			middle_q  <= '0;
			odd_q     <= 1'b0;
			started_q <= 1'b0;
		end else if (take) begin
			if (!started_q || !odd_q) begin
				left_q <= cur;
			end
			if (started_q && odd_q && !src_data.row_end) begin
				middle_q <= cur;
			end
			if (src_data.row_end) begin
				odd_q     <= 1'b0;
				started_q <= 1'b0;
			end else begin
				odd_q     <= !started_q || !odd_q;
				started_q <= 1'b1;
			end
		end
	end

endmodule

[src/hbd_queue.sv]
module hbd_queue #(
	parameter int unsigned DEPTH = hbd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hbd_pkg::hbd_op_t push_op,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output hbd_pkg::hbd_op_t head_op
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	hbd_pkg::hbd_op_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("occupancy did not follow push");
`endif

endmodule

[src/hbd_back.sv]
module hbd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  hbd_pkg::hbd_op_t  head_op,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output hbd_pkg::hbd_out_t res_data
);

	hbd_pkg::hbd_pix_t l;
	hbd_pkg::hbd_pix_t m;
	hbd_pkg::hbd_pix_t c;
	logic [3:0][7:0]   o;
	logic              res_valid_q;
	hbd_pkg::hbd_out_t res_data_q;

	assign l = head_op.left;
	assign m = head_op.middle;
	assign c = head_op.cur;

	always_comb begin
		if (head_op.kind == hbd_pkg::OP_TAP3) begin
			if (head_op.fmt == hbd_pkg::FMT_YUY2) begin
				o[0] = hbd_pkg::tap3(l[0], l[2], m[0]);
				o[1] = hbd_pkg::tap3(l[1], m[1], c[1]);
				o[2] = hbd_pkg::tap3(m[0], m[2], c[0]);
				o[3] = hbd_pkg::tap3(l[3], m[3], c[3]);
			end else begin
				for (int i = 0; i < 4; i++) begin
					o[i] = hbd_pkg::tap3(l[i], m[i], c[i]);
				end
			end
		end else begin
			if (head_op.fmt == hbd_pkg::FMT_YUY2) begin
				o[0] = hbd_pkg::tap3(l[0], l[2], c[0]);
				o[1] = hbd_pkg::tap2(l[1], c[1]);
				o[2] = hbd_pkg::tap2(c[0], c[2]);
				o[3] = hbd_pkg::tap2(l[3], c[3]);
			end else begin
				for (int i = 0; i < 4; i++) begin
					o[i] = hbd_pkg::tap2(l[i], c[i]);
				end
			end
		end
		// no alpha in rgb24
		if (head_op.fmt == hbd_pkg::FMT_RGB24) begin
			o[3] = '0;
		end
	end

	assign pop = !empty && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_data_q.out_a       <= o[0];
			res_data_q.out_b       <= o[1];
			res_data_q.out_c       <= o[2];
			res_data_q.out_d       <= o[3];
			res_data_q.out_row_end <= head_op.row_end;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

[dv/tb_horizontal_binomial_decimate_2to1.sv]
`timescale 1ns / 100ps

module tb_horizontal_binomial_decimate_2to1;

	// pixel format codes under short local names for the table
	localparam logic [1:0] FMT_YUY2  = hbd_pkg::FMT_YUY2;
	localparam logic [1:0] FMT_RGB24 = hbd_pkg::FMT_RGB24;
	localparam logic [1:0] FMT_RGB32 = hbd_pkg::FMT_RGB32;
	// pixel_format 3 has no name in the package; the block treats it as RGB32
	localparam logic [1:0] FMT_SPARE = 2'd3;

	localparam int DIR_N         = 23;
	localparam int RAND_ITEMS    = 1830;
	// cycles allowed after the last result before the format may change
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	// long receiver hold-off, enough to fill the job queue and the output register
	localparam int HOLD_CYCLES   = 80;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SHUT,
		RX_TOGGLE
	} rx_mode_t;

	// one row of the directed table; w* fields are only used where pin is set
	typedef struct packed {
		logic [1:0] fmt;
		logic [7:0] a, b, c, d;
		logic       last;
		logic       pin;
		logic [7:0] wa, wb, wc, wd;
		logic       wlast;
	} dir_row_t;

	// a result typed into the table, lined up with the src transaction that makes it
	typedef struct packed {
		logic              pin;
		hbd_pkg::hbd_out_t want;
	} pinned_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_wdata = 2'd0;
	logic              src_valid = 1'b0;
	logic              src_ready;
	hbd_pkg::hbd_in_t  src_data = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	hbd_pkg::hbd_out_t res_data;

	// predictor state, mirrors the row state of the block
	logic [1:0]        fmt_reg = FMT_YUY2;
	hbd_pkg::hbd_pix_t left_px = '0;
	hbd_pkg::hbd_pix_t mid_px = '0;
	logic              odd_pos = 1'b0;
	logic              row_open = 1'b0;

	hbd_pkg::hbd_out_t halved_q [$];
	pinned_t           pinned_q [$];

	int err_count = 0;
	int burst_left = 0;
	bit squeeze_req = 1'b0;

	// directed rows: extremes, all formats, short rows, mid-row format changes
	dir_row_t dir_rows [DIR_N] = '{
		// yuy2 straight after reset, no register write yet; all-ones in gives all-ones out
		'{FMT_YUY2, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_YUY2, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_YUY2, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0},
		// row closing on an even position: three-tap output carries the row end
		'{FMT_YUY2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_YUY2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		// single-item row, nothing comes out
		'{FMT_YUY2, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		// two-item row: two-tap close, first luma still three taps
		'{FMT_YUY2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_YUY2, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		// rgb24: fourth byte forced to zero
		'{FMT_RGB24, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_RGB24, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_RGB24, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1},
		'{FMT_RGB24, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_RGB24, 8'h80, 8'h7f, 8'h00, 8'hff, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		// rgb32 all zeros
		'{FMT_RGB32, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_RGB32, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_RGB32, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1},
		// rgb32 row switched to the undefined format half way
		'{FMT_RGB32, 8'haa, 8'h55, 8'h0f, 8'hf0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_RGB32, 8'h55, 8'haa, 8'hf0, 8'h0f, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_SPARE, 8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_SPARE, 8'h01, 8'hfe, 8'h01, 8'hfe, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		// rgb24 row finished as yuy2, state carried over
		'{FMT_RGB24, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_YUY2, 8'hfe, 8'h01, 8'h7f, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
		'{FMT_YUY2, 8'h03, 8'hfd, 8'hc0, 8'h3f, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}
	};

	horizontal_binomial_decimate_2to1 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// rounded 1-2-1 and rounded mean of two
	function automatic logic [7:0] avg121(input int x, input int y, input int z);
		return 8'((x + 2 * y + z + 2) >> 2);
	endfunction

	function automatic logic [7:0] avg11(input int x, input int y);
		return 8'((x + y + 1) >> 1);
	endfunction

	// one output pixel or pair from left, middle and current items
	function automatic hbd_pkg::hbd_out_t shrink(input hbd_pkg::hbd_kind_t kind,
			input logic [1:0] fmt, input hbd_pkg::hbd_pix_t l,
			input hbd_pkg::hbd_pix_t m, input hbd_pkg::hbd_pix_t c, input logic last);
		hbd_pkg::hbd_pix_t v;
		hbd_pkg::hbd_out_t o;
		for (int i = 0; i < 4; i++)
			v[i] = (kind == hbd_pkg::OP_TAP3) ? avg121(l[i], m[i], c[i]) :
				avg11(l[i], c[i]);
		if (fmt == FMT_YUY2) begin
			// luma runs Y0 Y1 Y0 Y1 across pairs, chroma stays per pair
			if (kind == hbd_pkg::OP_TAP3) begin
				v[0] = avg121(l[0], l[2], m[0]);
				v[2] = avg121(m[0], m[2], c[0]);
			end else begin
				v[0] = avg121(l[0], l[2], c[0]);
				v[2] = avg11(c[0], c[2]);
			end
		end else if (fmt == FMT_RGB24) begin
			v[3] = 8'h00;
		end
		o.out_a       = v[0];
		o.out_b       = v[1];
		o.out_c       = v[2];
		o.out_d       = v[3];
		o.out_row_end = last;
		return o;
	endfunction

	// advance the row state by one accepted item; returns 1 when a result is due
	function automatic bit take_pixel(input hbd_pkg::hbd_in_t px,
			output hbd_pkg::hbd_out_t res);
		hbd_pkg::hbd_pix_t cur;
		cur = {px.byte_d, px.byte_c, px.byte_b, px.byte_a};
		res = '0;
		if (!row_open) begin
			left_px  = cur;
			row_open = !px.row_end;
			odd_pos  = !px.row_end;
			return 1'b0;
		end
		if (odd_pos) begin
			if (px.row_end) begin
				res      = shrink(hbd_pkg::OP_TAP2, fmt_reg, left_px, mid_px, cur, 1'b1);
				odd_pos  = 1'b0;
				row_open = 1'b0;
				return 1'b1;
			end
			mid_px  = cur;
			odd_pos = 1'b0;
			return 1'b0;
		end
		res      = shrink(hbd_pkg::OP_TAP3, fmt_reg, left_px, mid_px, cur, px.row_end);
		left_px  = cur;
		odd_pos  = !px.row_end;
		row_open = !px.row_end;
		return 1'b1;
	endfunction

	// bytes lean towards the extremes so rounding at 0 and 255 is hit often
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// offer one src transaction, with bursts and random gaps in between
	task automatic offer(input hbd_pkg::hbd_in_t px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				src_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		src_valid <= 1'b1;
		src_data  <= px;
		do @(posedge clk); while (!src_ready);
	endtask

	// stop offering and let every outstanding result drain
	task automatic settle();
		@(negedge clk);
		src_valid <= 1'b0;
		while (halved_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, only once the block has gone quiet
	task automatic set_format(input logic [1:0] f);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= f;
		fmt_reg   = f;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// predict on every accepted src transaction
	always @(posedge clk) begin
		hbd_pkg::hbd_out_t guess;
		pinned_t           pin;
		bit                made;
		if (arst_n && src_valid && src_ready) begin
			made = take_pixel(src_data, guess);
			pin  = '0;
			if (pinned_q.size() != 0)
				pin = pinned_q.pop_front();
			if (made)
				halved_q.push_back(pin.pin ? pin.want : guess);
		end
	end

	// compare every accepted res transaction with the oldest expectation
	always @(posedge clk) begin
		hbd_pkg::hbd_out_t want;
		if (arst_n && res_valid && res_ready) begin
			if (halved_q.size() == 0) begin
				$error("res transaction with nothing expected: %h", res_data);
				err_count++;
			end else begin
				want = halved_q.pop_front();
				if (res_data.out_a !== want.out_a) begin
					$error("out_a: expected %0d, got %0d", want.out_a, res_data.out_a);
					err_count++;
				end
				if (res_data.out_b !== want.out_b) begin
					$error("out_b: expected %0d, got %0d", want.out_b, res_data.out_b);
					err_count++;
				end
				if (res_data.out_c !== want.out_c) begin
					$error("out_c: expected %0d, got %0d", want.out_c, res_data.out_c);
					err_count++;
				end
				if (res_data.out_d !== want.out_d) begin
					$error("out_d: expected %0d, got %0d", want.out_d, res_data.out_d);
					err_count++;
				end
				if (res_data.out_row_end !== want.out_row_end) begin
					$error("out_row_end: expected %0d, got %0d", want.out_row_end,
						res_data.out_row_end);
					err_count++;
				end
			end
		end
	end

	// receiver: stretches of open, coin-flip, shut and toggling ready,
	// plus a long hold-off on request so the queue backs up into src_ready
	initial begin
		rx_mode_t mode;
		int       span;
		@(posedge arst_n);
		forever begin
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					res_ready <= 1'b0;
				end
			end else begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(1, 30);
				repeat (span) begin
					@(negedge clk);
					case (mode)
						RX_OPEN:   res_ready <= 1'b1;
						RX_COIN:   res_ready <= ($urandom_range(0, 1) == 1);
						RX_SHUT:   res_ready <= 1'b0;
						RX_TOGGLE: res_ready <= !res_ready;
					endcase
				end
			end
		end
	end

	// stimulus: reset, directed table, then random rows in phases of one format
	initial begin
		hbd_pkg::hbd_in_t px;
		pinned_t          pin;
		dir_row_t         r;
		int               sent;
		int               phase;
		int               phase_len;
		int               row_left;
		int               pick;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed part, format written only where a row asks for a different one
		for (int i = 0; i < DIR_N; i++) begin
			r = dir_rows[i];
			if (r.fmt != fmt_reg)
				set_format(r.fmt);
			pin.pin              = r.pin;
			pin.want.out_a       = r.wa;
			pin.want.out_b       = r.wb;
			pin.want.out_c       = r.wc;
			pin.want.out_d       = r.wd;
			pin.want.out_row_end = r.wlast;
			pinned_q.push_back(pin);
			px.byte_a  = r.a;
			px.byte_b  = r.b;
			px.byte_c  = r.c;
			px.byte_d  = r.d;
			px.row_end = r.last;
			offer(px);
		end

		// random part; a phase may end mid-row, so the next format picks up that row
		sent     = 0;
		phase    = 0;
		row_left = 0;
		while (sent < RAND_ITEMS) begin
			set_format((phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3)));
			if (phase == 0 || $urandom_range(0, 4) == 0)
				squeeze_req = 1'b1;
			phase_len = $urandom_range(40, 160);
			for (int j = 0; j < phase_len && sent < RAND_ITEMS; j++) begin
				if (row_left == 0) begin
					pick = $urandom_range(0, 19);
					if (pick < 14)
						row_left = $urandom_range(1, 8);
					else if (pick < 19)
						row_left = $urandom_range(9, 32);
					else
						row_left = $urandom_range(33, 100);
				end
				px.byte_a  = pick_byte();
				px.byte_b  = pick_byte();
				px.byte_c  = pick_byte();
				px.byte_d  = pick_byte();
				px.row_end = (row_left == 1);
				row_left--;
				offer(px);
				sent++;
			end
			phase++;
		end

		// drain, then allow a tail for anything stray
		@(negedge clk);
		src_valid <= 1'b0;
		while (halved_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("horizontal_binomial_decimate_2to1: match");
		else
			$display("horizontal_binomial_decimate_2to1: mismatch");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("horizontal_binomial_decimate_2to1: mismatch");
		$finish;
	end

endmodule
